// ===== rtl/core/row_dirty_span_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// row dirty span tracker assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ROW_DIRTY_SPAN_TRACKER_ASSERT_SVH
`define ROW_DIRTY_SPAN_TRACKER_ASSERT_SVH

// same-cycle implication
`define RDST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rdst_pkg.sv =====
// ----------------------------------------------------------------------------
// rdst_pkg
// shared types and constants of the row dirty span tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdst_pkg;

  localparam int OP_W        = 2;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int MD_W        = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [OP_W-1:0] {
    OP_MARK  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_code_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] span_start;
    logic [COL_W-1:0] span_end;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] out_left;
    logic [COL_W-1:0] out_right;
    logic             out_valid;
    logic             out_last;
  } out_item_t;

  typedef struct packed {
    op_code_t         kind;
    logic             row_ok;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_SCAN,
    BK_WRITE,
    BK_EMIT,
    BK_EMPTY
  } back_state_t;

endpackage

// ===== rtl/core/rdst_front.sv =====
// ----------------------------------------------------------------------------
// rdst_front
// accepts input beats, clamps and orders the span, checks the row and drops
// beats that have no effect
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdst_front #(
  parameter int ROWS = 32,
  parameter int COLS = 80
) (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rdst_pkg::in_item_t   in_data,
  input  rdst_pkg::q_status_t  q_status,
  output logic                 q_push,
  output rdst_pkg::cmd_t       q_cmd
);

  localparam int LW = 9;

  logic [LW-1:0]                lim;
  logic [rdst_pkg::COL_W-1:0]   sat_a;
  logic [rdst_pkg::COL_W-1:0]   sat_b;
  logic                         row_ok;
  logic                         keep;
  rdst_pkg::op_code_t           kind;

  assign lim    = LW'(COLS - 1);
  assign sat_a  = (LW'(in_data.span_start) > lim) ? lim[rdst_pkg::COL_W-1:0]
                                                  : in_data.span_start;
  assign sat_b  = (LW'(in_data.span_end) > lim) ? lim[rdst_pkg::COL_W-1:0]
                                                : in_data.span_end;
  assign row_ok = LW'(in_data.row) < LW'(ROWS);
  assign kind   = rdst_pkg::op_code_t'(in_data.op);

  always_comb begin
    case (kind)
      rdst_pkg::OP_FLUSH: keep = 1'b1;
      rdst_pkg::OP_MARK,
      rdst_pkg::OP_CLEAR: keep = row_ok;
      default:            keep = 1'b0;
    endcase
  end

  assign in_stall     = q_status.full;
  assign q_push       = in_valid && !q_status.full && keep;
  assign q_cmd.kind   = kind;
  assign q_cmd.row_ok = row_ok;
  assign q_cmd.row    = in_data.row;
  assign q_cmd.left   = (sat_a > sat_b) ? sat_b : sat_a;
  assign q_cmd.right  = (sat_a > sat_b) ? sat_a : sat_b;

endmodule

// ===== rtl/core/rdst_queue.sv =====
// ----------------------------------------------------------------------------
// rdst_queue
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdst_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rdst_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output rdst_pkg::cmd_t       pop_cmd,
  output rdst_pkg::q_status_t  status
);

  rdst_pkg::cmd_t                 buf_r [rdst_pkg::QUEUE_DEPTH];
  logic [rdst_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [rdst_pkg::QPTR_W-1:0]    wr_ptr_nxt;
  logic [rdst_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [rdst_pkg::QPTR_W-1:0]    rd_ptr_nxt;
  logic [rdst_pkg::QPTR_W:0]      count_r;
  logic [rdst_pkg::QPTR_W:0]      count_nxt;

  assign status.full  = count_r == (rdst_pkg::QPTR_W+1)'(rdst_pkg::QUEUE_DEPTH);
  assign status.empty = count_r == '0;
  assign pop_cmd      = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (rdst_pkg::QPTR_W+1)'(push) - (rdst_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/rdst_back.sv =====
// ----------------------------------------------------------------------------
// rdst_back
// row table memory, entry-by-entry mark scan, flush emission and the
// output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdst_back #(
  parameter int ROWS          = 32,
  parameter int SPANS_PER_ROW = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rdst_pkg::MD_W-1:0] merge_dist,
  input  rdst_pkg::q_status_t       q_status,
  input  rdst_pkg::cmd_t            pop_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rdst_pkg::out_item_t       out_data
);

  localparam int S  = SPANS_PER_ROW;
  localparam int SW = (S > 1) ? $clog2(S) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = rdst_pkg::COL_W;
  localparam int CX = CW + 1;

  typedef logic [S-1:0][CW-1:0] col_vec_t;

  typedef struct packed {
    logic [S-1:0] used;
    col_vec_t     left;
    col_vec_t     right;
  } row_word_t;

  row_word_t              mem [ROWS];
  row_word_t              rd_word_r;
  row_word_t              wr_word;
  logic [ROWS-1:0]        row_valid_r;
  logic                   rd_valid_r;

  rdst_pkg::back_state_t  state_r;
  rdst_pkg::back_state_t  state_nxt;
  rdst_pkg::cmd_t         cmd_r;

  logic [SW-1:0]          k_r;
  logic [SW-1:0]          k_nxt;
  logic [S-1:0]           wk_used_r;
  logic [S-1:0]           wk_used_nxt;
  col_vec_t               wk_left_r;
  col_vec_t               wk_left_nxt;
  col_vec_t               wk_right_r;
  col_vec_t               wk_right_nxt;
  logic [CW-1:0]          lft_r;
  logic [CW-1:0]          lft_nxt;
  logic [CW-1:0]          rgt_r;
  logic [CW-1:0]          rgt_nxt;
  logic                   found_r;
  logic                   found_nxt;
  logic [SW-1:0]          fpos_r;
  logic [SW-1:0]          fpos_nxt;
  logic                   free_ok_r;
  logic                   free_ok_nxt;
  logic [SW-1:0]          free_idx_r;
  logic [SW-1:0]          free_idx_nxt;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  rdst_pkg::out_item_t    out_data_r;
  rdst_pkg::out_item_t    out_data_nxt;

  logic [RW-1:0]          rd_idx;
  logic [RW-1:0]          cmd_idx;
  logic [S-1:0]           base_used;
  logic                   k_last;
  logic                   can_load;
  logic                   emit;
  logic                   mem_we;
  logic                   rv_set;
  logic                   rv_clr;
  logic [RW-1:0]          rv_clr_idx;
  logic                   above_any;
  logic [CW-1:0]          cur_l;
  logic [CW-1:0]          cur_r;
  logic                   skip;
  logic                   touch;

  assign rd_idx    = pop_cmd.row_ok ? RW'(pop_cmd.row) : '0;
  assign cmd_idx   = cmd_r.row_ok ? RW'(cmd_r.row) : '0;
  assign base_used = (rd_valid_r && cmd_r.row_ok) ? rd_word_r.used : '0;
  assign k_last    = k_r == SW'(S - 1);
  assign can_load  = !out_valid_r || !out_stall;
  assign cur_l     = wk_left_r[k_r];
  assign cur_r     = wk_right_r[k_r];
  assign skip      = found_r && (fpos_r == k_r);
  assign touch     = !((({1'b0, rgt_r} + CX'(merge_dist)) < {1'b0, cur_l}) ||
                       ({1'b0, lft_r} > ({1'b0, cur_r} + CX'(merge_dist))));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    above_any = 1'b0;
    for (int j = 0; j < S; j++) begin
      if ((SW'(j) > k_r) && wk_used_r[j]) begin
        above_any = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rdst_pkg::BK_IDLE: begin
        if (!q_status.empty && (pop_cmd.kind != rdst_pkg::OP_CLEAR)) begin
          state_nxt = rdst_pkg::BK_LOAD;
        end
      end
      rdst_pkg::BK_LOAD: begin
        if (cmd_r.kind == rdst_pkg::OP_MARK) begin
          state_nxt = rdst_pkg::BK_SCAN;
        end else if (base_used == '0) begin
          state_nxt = rdst_pkg::BK_EMPTY;
        end else begin
          state_nxt = rdst_pkg::BK_EMIT;
        end
      end
      rdst_pkg::BK_SCAN: begin
        if (k_last) begin
          state_nxt = rdst_pkg::BK_WRITE;
        end
      end
      rdst_pkg::BK_WRITE: begin
        state_nxt = rdst_pkg::BK_IDLE;
      end
      rdst_pkg::BK_EMIT: begin
        if (k_last && (!wk_used_r[k_r] || can_load)) begin
          state_nxt = rdst_pkg::BK_IDLE;
        end
      end
      rdst_pkg::BK_EMPTY: begin
        if (can_load) begin
          state_nxt = rdst_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rdst_pkg::BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop        = 1'b0;
    emit         = 1'b0;
    mem_we       = 1'b0;
    rv_set       = 1'b0;
    rv_clr       = 1'b0;
    rv_clr_idx   = cmd_idx;
    wr_word      = '{used: wk_used_r, left: wk_left_r, right: wk_right_r};
    out_data_nxt = out_data_r;
    k_nxt        = k_r;
    wk_used_nxt  = wk_used_r;
    wk_left_nxt  = wk_left_r;
    wk_right_nxt = wk_right_r;
    lft_nxt      = lft_r;
    rgt_nxt      = rgt_r;
    found_nxt    = found_r;
    fpos_nxt     = fpos_r;
    free_ok_nxt  = free_ok_r;
    free_idx_nxt = free_idx_r;

    case (state_r)
      rdst_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          q_pop = 1'b1;
          if (pop_cmd.kind == rdst_pkg::OP_CLEAR) begin
            rv_clr     = pop_cmd.row_ok;
            rv_clr_idx = rd_idx;
          end
        end
      end
      rdst_pkg::BK_LOAD: begin
        k_nxt        = '0;
        wk_used_nxt  = base_used;
        wk_left_nxt  = rd_word_r.left;
        wk_right_nxt = rd_word_r.right;
        lft_nxt      = cmd_r.left;
        rgt_nxt      = cmd_r.right;
        found_nxt    = 1'b0;
        fpos_nxt     = '0;
        free_ok_nxt  = 1'b0;
        free_idx_nxt = '0;
        if (cmd_r.kind == rdst_pkg::OP_MARK) begin
          if (&base_used) begin
            // full row, entry 0 absorbs the span first
            lft_nxt   = (cmd_r.left < rd_word_r.left[0]) ? cmd_r.left : rd_word_r.left[0];
            rgt_nxt   = (cmd_r.right > rd_word_r.right[0]) ? cmd_r.right
                                                           : rd_word_r.right[0];
            found_nxt = 1'b1;
          end
        end else begin
          rv_clr = cmd_r.row_ok;
        end
      end
      rdst_pkg::BK_SCAN: begin
        k_nxt = k_r + 1'b1;
        if (!skip) begin
          if (!wk_used_r[k_r]) begin
            free_ok_nxt  = 1'b1;
            free_idx_nxt = k_r;
          end else if (touch) begin
            lft_nxt = (cur_l < lft_r) ? cur_l : lft_r;
            rgt_nxt = (cur_r > rgt_r) ? cur_r : rgt_r;
            if (found_r) begin
              wk_used_nxt[k_r] = 1'b0;
            end else begin
              found_nxt = 1'b1;
              fpos_nxt  = k_r;
            end
          end
        end
      end
      rdst_pkg::BK_WRITE: begin
        mem_we = 1'b1;
        rv_set = 1'b1;
        if (found_r) begin
          wr_word.left[fpos_r]  = lft_r;
          wr_word.right[fpos_r] = rgt_r;
        end else if (free_ok_r) begin
          wr_word.left[free_idx_r]  = lft_r;
          wr_word.right[free_idx_r] = rgt_r;
          wr_word.used[free_idx_r]  = 1'b1;
        end
      end
      rdst_pkg::BK_EMIT: begin
        if (!wk_used_r[k_r]) begin
          k_nxt = k_r + 1'b1;
        end else if (can_load) begin
          emit         = 1'b1;
          k_nxt        = k_r + 1'b1;
          out_data_nxt = '{out_left: cur_l, out_right: cur_r,
                           out_valid: 1'b1, out_last: !above_any};
        end
      end
      rdst_pkg::BK_EMPTY: begin
        if (can_load) begin
          emit         = 1'b1;
          out_data_nxt = '{out_left: '0, out_right: '0,
                           out_valid: 1'b0, out_last: 1'b1};
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdst_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (rv_clr) begin
        row_valid_r[rv_clr_idx] <= 1'b0;
      end
      if (rv_set) begin
        row_valid_r[cmd_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r      <= pop_cmd;
      rd_valid_r <= row_valid_r[rd_idx];
    end
    out_data_r <= out_data_nxt;
    k_r        <= k_nxt;
    wk_used_r  <= wk_used_nxt;
    wk_left_r  <= wk_left_nxt;
    wk_right_r <= wk_right_nxt;
    lft_r      <= lft_nxt;
    rgt_r      <= rgt_nxt;
    found_r    <= found_nxt;
    fpos_r     <= fpos_nxt;
    free_ok_r  <= free_ok_nxt;
    free_idx_r <= free_idx_nxt;
  end

  // row table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd_idx] <= wr_word;
    end
    if (q_pop) begin
      rd_word_r <= mem[rd_idx];
    end
  end

endmodule

// ===== rtl/core/row_dirty_span_tracker.sv =====
// ----------------------------------------------------------------------------
// row_dirty_span_tracker
// per-row dirty column span table with mark, flush and clear operations
// ----------------------------------------------------------------------------
// The front end takes one beat per cycle while the two-entry command queue
// is not full (in_stall is raised when it is), so beats are accepted while
// the back end is busy. The back end handles one command at a time: a mark
// reads the row word, compares one span entry per cycle and writes the row
// word back; a flush of a row that holds spans gives one result beat per
// used entry, waiting while the result channel stalls; a flush of an empty
// row gives a single empty beat; a clear is done as it is popped from the
// queue. Mark and flush time is set by the sequential entry scan over the
// row word held in the single-port row memory. Rows are tracked by one valid
// bit each, so there is no clearing pass after reset. Marks, clears with a
// row past ROWS and the unused opcode are dropped at the front end.
`timescale 1ns / 1ps

`include "row_dirty_span_tracker_assert.svh"

module row_dirty_span_tracker #(
  parameter int ROWS          = 32,
  parameter int COLS          = 80,
  parameter int SPANS_PER_ROW = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rdst_pkg::MD_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rdst_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rdst_pkg::out_item_t       out_data
);

  logic [rdst_pkg::MD_W-1:0] merge_dist_r;
  logic [rdst_pkg::MD_W-1:0] merge_dist_nxt;
  rdst_pkg::q_status_t       q_status;
  rdst_pkg::cmd_t            push_cmd;
  rdst_pkg::cmd_t            pop_cmd;
  logic                      q_push;
  logic                      q_pop;

  assign merge_dist_nxt = cfg_wr_en ? cfg_wr_data : merge_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_dist_r <= rdst_pkg::MD_W'(1);
    end else begin
      merge_dist_r <= merge_dist_nxt;
    end
  end

  rdst_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  rdst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  rdst_back #(
    .ROWS          (ROWS),
    .SPANS_PER_ROW (SPANS_PER_ROW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .merge_dist (merge_dist_r),
    .q_status   (q_status),
    .pop_cmd    (pop_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `RDST_ASSERT_NOW(a_empty_is_last, out_valid && !out_data.out_valid, out_data.out_last, "empty flush beat without last")
  `RDST_ASSERT_NOW(a_empty_zero_cols, out_valid && !out_data.out_valid, (out_data.out_left == '0) && (out_data.out_right == '0), "empty flush beat with nonzero columns")
  `RDST_ASSERT_NOW(a_span_ordered, out_valid && out_data.out_valid, out_data.out_left <= out_data.out_right, "emitted span with left above right")
  `RDST_ASSERT_NEXT(a_push_fills, q_push, !q_status.empty, "command queue empty after a push")

endmodule

// ===== test/rdst_span_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdst_span_checker
// Watches the configuration port and both beat channels of the row dirty
// span tracker. It keeps its own copy of the span tables and the merge
// distance, predicts the span beats that each accepted input beat causes,
// and compares every accepted result beat, field by field, in order.
// ----------------------------------------------------------------------------

module rdst_span_checker
  import rdst_pkg::*;
#(
  parameter int ROWS          = 32,
  parameter int COLS          = 80,
  parameter int SPANS_PER_ROW = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [MD_W-1:0]  cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  output int               fail_count,
  output int               pending,
  output int               beats_seen,
  output int               results_seen
);

  localparam int ENTRIES = ROWS * SPANS_PER_ROW;

  logic [MD_W-1:0]  merge_dist;
  bit               span_used  [ENTRIES];
  logic [COL_W-1:0] span_left  [ENTRIES];
  logic [COL_W-1:0] span_right [ENTRIES];
  logic [4:0]       free_slots [ROWS];
  out_item_t        expected_spans [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    beats_seen   = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  function automatic void clear_table_row(input int r);
    int s;
    for (int k = 0; k < SPANS_PER_ROW; k++) begin
      s = r * SPANS_PER_ROW + k;
      span_used[s]  = 1'b0;
      span_left[s]  = '0;
      span_right[s] = COL_W'(COLS - 1);
    end
    free_slots[r] = 5'(SPANS_PER_ROW);
  endfunction

  function automatic void mark_row(input int r, input int lft, input int rgt);
    int  base;
    int  d;
    int  s;
    int  f;
    int  fpos;
    int  freeidx;
    bit  found;
    base    = r * SPANS_PER_ROW;
    d       = int'(merge_dist);
    found   = 1'b0;
    fpos    = -1;
    freeidx = -1;
    // full row: entry 0 swallows the span first
    if (free_slots[r] == 0) begin
      if (lft < int'(span_left[base])) span_left[base] = COL_W'(lft);
      else lft = int'(span_left[base]);
      if (rgt > int'(span_right[base])) span_right[base] = COL_W'(rgt);
      else rgt = int'(span_right[base]);
      found = 1'b1;
      fpos  = 0;
    end
    for (int k = 0; k < SPANS_PER_ROW; k++) begin
      s = base + k;
      if (k == fpos) continue;
      if (!span_used[s]) begin
        freeidx = k;
        continue;
      end
      if (rgt + d < int'(span_left[s]) || lft > int'(span_right[s]) + d) continue;
      if (found) begin
        f = base + fpos;
        if (int'(span_left[s]) < lft) lft = int'(span_left[s]);
        if (int'(span_right[s]) > rgt) rgt = int'(span_right[s]);
        span_left[f]  = COL_W'(lft);
        span_right[f] = COL_W'(rgt);
        span_used[s]  = 1'b0;
        if (free_slots[r] < SPANS_PER_ROW) free_slots[r] = free_slots[r] + 5'd1;
      end else begin
        if (lft < int'(span_left[s])) span_left[s] = COL_W'(lft);
        else lft = int'(span_left[s]);
        if (rgt > int'(span_right[s])) span_right[s] = COL_W'(rgt);
        else rgt = int'(span_right[s]);
        found = 1'b1;
        fpos  = k;
      end
    end
    if (!found && freeidx >= 0) begin
      s = base + freeidx;
      span_left[s]  = COL_W'(lft);
      span_right[s] = COL_W'(rgt);
      span_used[s]  = 1'b1;
      if (free_slots[r] > 0) free_slots[r] = free_slots[r] - 5'd1;
    end
  endfunction

  function automatic void predict_beat(input in_item_t b);
    int        r;
    int        a;
    int        e;
    int        t;
    int        s;
    int        last_k;
    out_item_t span;
    r = int'(b.row);
    a = int'(b.span_start);
    e = int'(b.span_end);
    case (op_code_t'(b.op))
      OP_MARK: begin
        if (r < ROWS) begin
          if (a > COLS - 1) a = COLS - 1;
          if (e > COLS - 1) e = COLS - 1;
          if (a > e) begin
            t = a;
            a = e;
            e = t;
          end
          mark_row(r, a, e);
        end
      end
      OP_FLUSH: begin
        last_k = -1;
        if (r < ROWS) begin
          for (int k = 0; k < SPANS_PER_ROW; k++)
            if (span_used[r * SPANS_PER_ROW + k]) last_k = k;
          for (int k = 0; k <= last_k; k++) begin
            s = r * SPANS_PER_ROW + k;
            if (!span_used[s]) continue;
            span.out_left  = span_left[s];
            span.out_right = span_right[s];
            span.out_valid = 1'b1;
            span.out_last  = (k == last_k);
            expected_spans.push_back(span);
          end
          clear_table_row(r);
        end
        if (last_k < 0) begin
          span = '0;
          span.out_last = 1'b1;
          expected_spans.push_back(span);
        end
      end
      OP_CLEAR: begin
        if (r < ROWS) clear_table_row(r);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      merge_dist = MD_W'(1);
      for (int r = 0; r < ROWS; r++) clear_table_row(r);
      expected_spans.delete();
    end else begin
      if (cfg_wr_en) merge_dist = cfg_wr_data;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_spans.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
        end else begin
          want = expected_spans.pop_front();
          if (out_data.out_left != want.out_left)
            report_mismatch($sformatf("beat %0d out_left got %0d expected %0d",
                                      results_seen, out_data.out_left, want.out_left));
          if (out_data.out_right != want.out_right)
            report_mismatch($sformatf("beat %0d out_right got %0d expected %0d",
                                      results_seen, out_data.out_right, want.out_right));
          if (out_data.out_valid != want.out_valid)
            report_mismatch($sformatf("beat %0d out_valid got %0b expected %0b",
                                      results_seen, out_data.out_valid, want.out_valid));
          if (out_data.out_last != want.out_last)
            report_mismatch($sformatf("beat %0d out_last got %0b expected %0b",
                                      results_seen, out_data.out_last, want.out_last));
        end
      end
      if (in_valid && !in_stall) begin
        beats_seen++;
        predict_beat(in_data);
      end
    end
    pending <= expected_spans.size();
  end

endmodule

// ===== test/tb_row_dirty_span_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_row_dirty_span_tracker
// Drives mark, flush and clear beats into the row dirty span tracker under
// several merge distances, with random gaps on the sender and random stalls
// on the receiver, including one long receiver hold-off. A checker beside
// the block predicts and compares every span beat; this module gives the
// verdict.
// ----------------------------------------------------------------------------

module tb_row_dirty_span_tracker;
  import rdst_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_BEATS  = 100;
  localparam int SETTLE       = 40;
  localparam int SQUEEZE_LEN  = 300;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [MD_W-1:0]  cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;

  int fail_count;
  int pending;
  int beats_seen;
  int results_seen;
  int cycle_count;
  int settings_used;
  bit squeeze_req;
  bit squeezed;

  row_dirty_span_tracker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  rdst_span_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .beats_seen   (beats_seen),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout with %0d span beats outstanding", pending);
      $display("row_dirty_span_tracker: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t mk_beat(input op_code_t op, input int row,
                                       input int a, input int b);
    in_item_t beat;
    beat.op         = op;
    beat.row        = ROW_W'(row);
    beat.span_start = COL_W'(a);
    beat.span_end   = COL_W'(b);
    return beat;
  endfunction

  function automatic in_item_t rand_beat();
    int       r;
    int       a;
    op_code_t op;
    in_item_t beat;
    r = $urandom_range(0, 99);
    if (r < 70) op = OP_MARK;
    else if (r < 84) op = OP_FLUSH;
    else if (r < 92) op = OP_CLEAR;
    else op = OP_NONE;
    beat.op  = op;
    beat.row = ($urandom_range(0, 9) < 7) ? ROW_W'($urandom_range(0, 3))
                                          : ROW_W'($urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < 80) begin
      a = $urandom_range(0, 79);
      beat.span_start = COL_W'(a);
      beat.span_end   = COL_W'(a + $urandom_range(0, 8));
    end else if (r < 92) begin
      beat.span_start = COL_W'($urandom_range(0, 127));
      beat.span_end   = COL_W'($urandom_range(0, 127));
    end else begin
      a = $urandom_range(10, 79);
      beat.span_start = COL_W'(a);
      beat.span_end   = COL_W'(a - $urandom_range(1, 10));
    end
    return beat;
  endfunction

  // entered and left at a falling edge
  task automatic send_beat(input in_item_t beat, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_merge_distance(input int md);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= MD_W'(md);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  task automatic drain_idle();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // receiver: random stall runs, one long hold-off on request
  initial begin
    int r;
    int len;
    int held;
    out_stall = 1'b0;
    squeezed  = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        out_stall <= 1'b1;
        held = 0;
        while (held < SQUEEZE_LEN) begin
          @(negedge clk);
          held++;
        end
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          out_stall <= 1'b0;
          len = 60;
        end else if (r < 55) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 8);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(10, 40);
        end
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  initial begin
    in_item_t beat;
    in_item_t directed [$];
    int       phase_md [5];
    int       sent;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    squeeze_req   = 1'b0;
    settings_used = 1;
    phase_md = '{15, 0, 1, 8, $urandom_range(2, 14)};

    // empty row, column extremes, saturation and reversed spans
    directed.push_back(mk_beat(OP_FLUSH, 0, 0, 0));
    directed.push_back(mk_beat(OP_MARK,  0, 0, 0));
    directed.push_back(mk_beat(OP_MARK,  0, 79, 79));
    directed.push_back(mk_beat(OP_MARK,  0, 127, 100));
    directed.push_back(mk_beat(OP_MARK,  0, 50, 10));
    directed.push_back(mk_beat(OP_FLUSH, 0, 127, 127));
    directed.push_back(mk_beat(OP_MARK,  31, 0, 127));
    directed.push_back(mk_beat(OP_FLUSH, 31, 0, 0));
    // fill a row, then a fifth span lands on the full row
    directed.push_back(mk_beat(OP_MARK,  5, 0, 2));
    directed.push_back(mk_beat(OP_MARK,  5, 10, 12));
    directed.push_back(mk_beat(OP_MARK,  5, 20, 22));
    directed.push_back(mk_beat(OP_MARK,  5, 30, 32));
    directed.push_back(mk_beat(OP_MARK,  5, 60, 61));
    directed.push_back(mk_beat(OP_FLUSH, 5, 0, 0));
    // gap just past the merge distance, then a bridging span
    directed.push_back(mk_beat(OP_MARK,  6, 10, 20));
    directed.push_back(mk_beat(OP_MARK,  6, 22, 25));
    directed.push_back(mk_beat(OP_MARK,  6, 21, 21));
    directed.push_back(mk_beat(OP_FLUSH, 6, 0, 0));
    directed.push_back(mk_beat(OP_MARK,  6, 40, 45));
    directed.push_back(mk_beat(OP_CLEAR, 6, 0, 0));
    directed.push_back(mk_beat(OP_FLUSH, 6, 0, 0));
    directed.push_back(mk_beat(OP_NONE,  7, 127, 127));
    directed.push_back(mk_beat(OP_MARK,  7, 5, 5));
    directed.push_back(mk_beat(OP_FLUSH, 7, 0, 0));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_beat(directed[i], pick_gap());
    in_valid <= 1'b0;
    drain_idle();

    foreach (phase_md[p]) begin
      write_merge_distance(phase_md[p]);
      if (p == 2) squeeze_req <= 1'b1;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        beat = rand_beat();
        if (beat.op != OP_NONE) sent++;
        send_beat(beat, ((sent % 50) < 12) ? 0 : pick_gap());
      end
      in_valid <= 1'b0;
      drain_idle();
    end

    $display("ran %0d input beats and checked %0d span beats over %0d merge distances",
             beats_seen, results_seen, settings_used);
    if (fail_count == 0) begin
      $display("row_dirty_span_tracker: match");
    end else begin
      $display("%0d field mismatches", fail_count);
      $display("row_dirty_span_tracker: mismatch");
    end
    $finish;
  end

endmodule
